// ===== rtl/prm_pkg.sv =====
// shared types and constants for the ping round-trip monitor
`default_nettype none

package prm_pkg;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [15:0] PACKET_BYTES = 16'd16;

  localparam logic [13:0] INTERVAL_MIN   = 14'd100;
  localparam logic [13:0] INTERVAL_MAX   = 14'd10000;
  localparam logic [13:0] INTERVAL_RESET = 14'd1000;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd5000;

  localparam logic REG_INTERVAL = 1'b0;
  localparam logic REG_TIMEOUT  = 1'b1;

  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_RESP  = 3'd1;
  localparam logic [2:0] ACT_START = 3'd2;
  localparam logic [2:0] ACT_STOP  = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_LOST = 2'd1;
  localparam logic [1:0] KIND_RTT  = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [47:0] now_ms;
    logic        link_accepts;
    logic [63:0] resp_timestamp_us;
    logic [15:0] resp_length;
  } cmd_t;

  typedef struct packed {
    logic        send_now;
    logic [31:0] send_seq;
    logic [57:0] send_stamp_us;
    logic [1:0]  event_kind;
    logic [31:0] rtt_us;
    logic [31:0] sent_count;
    logic [31:0] received_count;
    logic [31:0] lost_count;
    logic [31:0] avg_rtt_us;
    logic [31:0] min_rtt_us;
    logic [31:0] max_rtt_us;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/prm_div.sv =====
// iterative 32-bit restoring divider, one quotient bit per cycle
`default_nettype none

module prm_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [31:0]       dividend,
  input  wire logic [31:0]       divisor,
  output logic                   done,
  output logic [31:0]            quotient
);

  logic        busy;
  logic [4:0]  count;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [32:0] shifted;
  logic [32:0] trial;
  logic        fits;

  assign shifted  = {rem, quo[31]};
  assign trial    = shifted - {1'b0, divisor};
  assign fits     = (shifted >= {1'b0, divisor});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= !start && busy && (count == 5'd31);
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 5'd1;
        if (count == 5'd31) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= shifted[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  property p_no_restart;
    @(posedge clk) disable iff (rst) start |-> !busy;
  endproperty
  a_no_restart: assert property (p_no_restart)
    else $error("divider started while busy");

  property p_done_after_busy;
    @(posedge clk) disable iff (rst) done |-> $past(busy);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy)
    else $error("divider done without a running divide");

  property p_done_ends_busy;
    @(posedge clk) disable iff (rst) done |-> !busy;
  endproperty
  a_done_ends_busy: assert property (p_done_ends_busy)
    else $error("divider still busy at done");

endmodule

`default_nettype wire

// ===== rtl/ping_rtt_monitor.sv =====
// top level of the ping round-trip monitor: sequencer, statistics and register port
`default_nettype none

// Each request (tick, response, start, stop or clear) goes through these steps from
// acceptance until its result is ready: S_STAMP forms the microsecond stamp, for a
// tick S_APPLY and S_INTERVAL run the timeout and interval checks through a shared
// 48-bit subtract and compare unit, and the average takes a bit-serial divide plus
// its handoff. cmd_stall stays high until the result moves to the output register;
// a finished result may wait there while the next request is accepted.

module ping_rtt_monitor (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [prm_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [prm_pkg::DATA_W-1:0]    pwdata,
  output logic      [prm_pkg::DATA_W-1:0]    prdata,
  output logic                               pready,
  input  wire logic                          cmd_valid,
  output logic                               cmd_stall,
  input  wire prm_pkg::cmd_t                 cmd,
  output logic                               stat_valid,
  input  wire logic                          stat_stall,
  output prm_pkg::stat_t                     stat
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_STAMP    = 6'b000010,
    S_APPLY    = 6'b000100,
    S_INTERVAL = 6'b001000,
    S_DIV      = 6'b010000,
    S_FIN      = 6'b100000
  } state_t;

  state_t state;

  logic [13:0] period_ms;
  logic [15:0] timeout_ms;
  logic [13:0] wr_interval;
  logic        cfg_wr;

  prm_pkg::cmd_t item;
  logic [57:0]   stamp;
  logic [57:0]   now_ext;

  logic        active;
  logic        awaiting;
  logic [31:0] next_seq;
  logic [47:0] last_send_ms;
  logic [47:0] pending_since_ms;
  logic [31:0] sent_total;
  logic [31:0] recv_total;
  logic [31:0] lost_total;
  logic [31:0] rtt_sum;
  logic [31:0] rtt_min;
  logic [31:0] rtt_max;

  logic        send_now;
  logic [31:0] send_seq;
  logic [1:0]  kind;
  logic [31:0] rtt;
  logic [31:0] rtt_cur;
  logic        stat_load;

  // shared elapsed-time unit
  logic [47:0] since_sel;
  logic [47:0] limit_sel;
  logic [48:0] diff;
  logic        elapsed_ok;

  logic        div_start;
  logic        div_done;
  logic [31:0] div_quo;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    if (pwdata[13:0] < prm_pkg::INTERVAL_MIN) begin
      wr_interval = prm_pkg::INTERVAL_MIN;
    end else if (pwdata[13:0] > prm_pkg::INTERVAL_MAX) begin
      wr_interval = prm_pkg::INTERVAL_MAX;
    end else begin
      wr_interval = pwdata[13:0];
    end
  end

  always_comb begin
    if (paddr[2] == prm_pkg::REG_TIMEOUT) begin
      prdata = {16'd0, timeout_ms};
    end else begin
      prdata = {18'd0, period_ms};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_ms  <= prm_pkg::INTERVAL_RESET;
      timeout_ms <= prm_pkg::TIMEOUT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == prm_pkg::REG_TIMEOUT) begin
        timeout_ms <= pwdata[15:0];
      end else begin
        period_ms <= wr_interval;
      end
    end
  end

  assign cmd_stall = (state != S_IDLE);
  assign stat_load = (state == S_FIN) && (!stat_valid || !stat_stall);

  // now_ms * 1000 as 1024 - 16 - 8
  assign now_ext = {10'd0, item.now_ms};

  assign since_sel = (state == S_APPLY) ? pending_since_ms : last_send_ms;
  assign limit_sel = (state == S_APPLY) ? {32'd0, timeout_ms} : {34'd0, period_ms};
  assign diff      = {1'b0, item.now_ms} - {1'b0, since_sel};

  always_comb begin
    if (diff[48]) begin
      elapsed_ok = 1'b0;
    end else if (state == S_APPLY) begin
      elapsed_ok = (diff[47:0] > limit_sel);
    end else begin
      elapsed_ok = (diff[47:0] >= limit_sel);
    end
  end

  assign rtt_cur = stamp[31:0] - item.resp_timestamp_us[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      active           <= 1'b0;
      awaiting         <= 1'b0;
      next_seq         <= '0;
      last_send_ms     <= '0;
      pending_since_ms <= '0;
      sent_total       <= '0;
      recv_total       <= '0;
      lost_total       <= '0;
      rtt_sum          <= '0;
      rtt_min          <= '1;
      rtt_max          <= '0;
      div_start        <= 1'b0;
      stat_valid       <= 1'b0;
    end else begin
      div_start <= (state == S_INTERVAL) ||
                   ((state == S_APPLY) && (item.action != prm_pkg::ACT_TICK));
      if (stat_load) begin
        stat_valid <= 1'b1;
      end else if (stat_valid && !stat_stall) begin
        stat_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            state <= S_STAMP;
          end
        end
        S_STAMP: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          state <= (item.action == prm_pkg::ACT_TICK) ? S_INTERVAL : S_DIV;
          case (item.action)
            prm_pkg::ACT_TICK: begin
              if (active && awaiting && elapsed_ok) begin
                lost_total <= lost_total + 32'd1;
                awaiting   <= 1'b0;
              end
            end
            prm_pkg::ACT_RESP: begin
              if (awaiting && item.resp_length == prm_pkg::PACKET_BYTES) begin
                recv_total <= recv_total + 32'd1;
                rtt_sum    <= rtt_sum + rtt_cur;
                if (rtt_cur < rtt_min) begin
                  rtt_min <= rtt_cur;
                end
                if (rtt_cur > rtt_max) begin
                  rtt_max <= rtt_cur;
                end
                awaiting <= 1'b0;
              end
            end
            prm_pkg::ACT_START: begin
              if (!active) begin
                active       <= 1'b1;
                last_send_ms <= '0;
                awaiting     <= 1'b0;
              end
            end
            prm_pkg::ACT_STOP: begin
              if (active) begin
                active   <= 1'b0;
                awaiting <= 1'b0;
              end
            end
            prm_pkg::ACT_CLEAR: begin
              sent_total <= '0;
              recv_total <= '0;
              lost_total <= '0;
              rtt_sum    <= '0;
              rtt_min    <= '1;
              rtt_max    <= '0;
              next_seq   <= '0;
            end
            default: begin
            end
          endcase
        end
        S_INTERVAL: begin
          state <= S_DIV;
          if (active && !awaiting && elapsed_ok) begin
            next_seq <= next_seq + 32'd1;
            if (item.link_accepts) begin
              pending_since_ms <= item.now_ms;
              last_send_ms     <= item.now_ms;
              awaiting         <= 1'b1;
              sent_total       <= sent_total + 32'd1;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (stat_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // per-request payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        item     <= cmd;
        send_now <= 1'b0;
        send_seq <= '0;
        kind     <= prm_pkg::KIND_NONE;
        rtt      <= '0;
      end
      S_STAMP: begin
        stamp <= (now_ext << 10) - (now_ext << 4) - (now_ext << 3);
      end
      S_APPLY: begin
        if (item.action == prm_pkg::ACT_TICK) begin
          if (active && awaiting && elapsed_ok) begin
            kind <= prm_pkg::KIND_LOST;
          end
        end else if (item.action == prm_pkg::ACT_RESP) begin
          if (awaiting && item.resp_length == prm_pkg::PACKET_BYTES) begin
            kind <= prm_pkg::KIND_RTT;
            rtt  <= rtt_cur;
          end
        end
      end
      S_INTERVAL: begin
        if (active && !awaiting && elapsed_ok) begin
          send_now <= 1'b1;
          send_seq <= next_seq;
        end
      end
      S_FIN: begin
        if (stat_load) begin
          stat.send_now       <= send_now;
          stat.send_seq       <= send_seq;
          stat.send_stamp_us  <= send_now ? stamp : 58'd0;
          stat.event_kind     <= kind;
          stat.rtt_us         <= rtt;
          stat.sent_count     <= sent_total;
          stat.received_count <= recv_total;
          stat.lost_count     <= lost_total;
          stat.avg_rtt_us     <= (recv_total == 32'd0) ? 32'd0 : div_quo;
          stat.min_rtt_us     <= (rtt_min == '1) ? 32'd0 : rtt_min;
          stat.max_rtt_us     <= rtt_max;
        end
      end
      default: begin
      end
    endcase
  end

  prm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rtt_sum),
    .divisor  (recv_total),
    .done     (div_done),
    .quotient (div_quo)
  );

  property p_awaiting_needs_active;
    @(posedge clk) disable iff (rst) awaiting |-> active;
  endproperty
  a_awaiting_needs_active: assert property (p_awaiting_needs_active)
    else $error("outstanding request while stopped");

  property p_accept_starts_seq;
    @(posedge clk) disable iff (rst) (cmd_valid && !cmd_stall) |=> state == S_STAMP;
  endproperty
  a_accept_starts_seq: assert property (p_accept_starts_seq)
    else $error("accepted request did not start the sequence");

  property p_done_in_div;
    @(posedge clk) disable iff (rst) div_done |-> state == S_DIV;
  endproperty
  a_done_in_div: assert property (p_done_in_div)
    else $error("divide finished outside the divide step");

  property p_result_from_fin;
    @(posedge clk) disable iff (rst) $rose(stat_valid) |-> $past(state == S_FIN);
  endproperty
  a_result_from_fin: assert property (p_result_from_fin)
    else $error("result loaded outside the finish step");

  property p_rtt_no_send;
    @(posedge clk) disable iff (rst)
      (stat_valid && stat.event_kind == prm_pkg::KIND_RTT) |-> !stat.send_now;
  endproperty
  a_rtt_no_send: assert property (p_rtt_no_send)
    else $error("round trip and send in one result");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// self-checking testbench for the ping round-trip monitor
module tb;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_PER_PHASE = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [prm_pkg::ADDR_W-1:0] paddr = '0;
  logic [prm_pkg::DATA_W-1:0] pwdata = '0;
  logic [prm_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  prm_pkg::cmd_t cmd = '0;
  logic stat_valid;
  logic stat_stall = 1'b0;
  prm_pkg::stat_t stat;

  ping_rtt_monitor dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .stat_valid(stat_valid),
    .stat_stall(stat_stall),
    .stat(stat)
  );

  // monitor state as the predictor sees it
  logic [13:0] cfg_interval = prm_pkg::INTERVAL_RESET;
  logic [15:0] cfg_timeout = prm_pkg::TIMEOUT_RESET;
  logic run_on = 1'b0;
  logic waiting = 1'b0;
  logic [31:0] seq_next = '0;
  logic [47:0] last_tx_ms = '0;
  logic [47:0] pend_ms = '0;
  logic [31:0] n_sent = '0;
  logic [31:0] n_recv = '0;
  logic [31:0] n_lost = '0;
  logic [31:0] sum_rtt = '0;
  logic [31:0] lo_rtt = '1;
  logic [31:0] hi_rtt = '0;

  prm_pkg::cmd_t req_queue[$];
  prm_pkg::stat_t stats_due[$];
  prm_pkg::stat_t got_stats;
  prm_pkg::stat_t want_stats;
  logic [47:0] clock_ms = 48'd20000;
  logic quiet = 1'b0;
  logic cmd_took = 1'b0;
  int cmd_gap = 0;
  int stall_gap = 0;
  int fails = 0;
  int cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic predict_stats(input prm_pkg::cmd_t c, output prm_pkg::stat_t s);
    logic [63:0] us;
    logic [63:0] diff;
    logic [31:0] r;
    s = '0;
    us = {16'b0, c.now_ms} * 64'd1000;
    case (c.action)
      prm_pkg::ACT_TICK: begin
        if (run_on) begin
          if (waiting && c.now_ms >= pend_ms && (c.now_ms - pend_ms) > cfg_timeout) begin
            n_lost++;
            waiting = 1'b0;
            s.event_kind = prm_pkg::KIND_LOST;
          end
          if (!waiting && c.now_ms >= last_tx_ms &&
              (c.now_ms - last_tx_ms) >= cfg_interval) begin
            s.send_now = 1'b1;
            s.send_seq = seq_next;
            s.send_stamp_us = us[57:0];
            seq_next++;
            if (c.link_accepts) begin
              pend_ms = c.now_ms;
              last_tx_ms = c.now_ms;
              waiting = 1'b1;
              n_sent++;
            end
          end
        end
      end
      prm_pkg::ACT_RESP: begin
        if (waiting && c.resp_length == prm_pkg::PACKET_BYTES) begin
          diff = us - c.resp_timestamp_us;
          r = diff[31:0];
          n_recv++;
          sum_rtt += r;
          if (r < lo_rtt) lo_rtt = r;
          if (r > hi_rtt) hi_rtt = r;
          waiting = 1'b0;
          s.event_kind = prm_pkg::KIND_RTT;
          s.rtt_us = r;
        end
      end
      prm_pkg::ACT_START: begin
        if (!run_on) begin
          run_on = 1'b1;
          last_tx_ms = '0;
          waiting = 1'b0;
        end
      end
      prm_pkg::ACT_STOP: begin
        if (run_on) begin
          run_on = 1'b0;
          waiting = 1'b0;
        end
      end
      prm_pkg::ACT_CLEAR: begin
        n_sent = '0;
        n_recv = '0;
        n_lost = '0;
        sum_rtt = '0;
        lo_rtt = '1;
        hi_rtt = '0;
        seq_next = '0;
      end
      default: ;
    endcase
    s.sent_count = n_sent;
    s.received_count = n_recv;
    s.lost_count = n_lost;
    s.avg_rtt_us = (n_recv != 0) ? sum_rtt / n_recv : '0;
    s.min_rtt_us = (lo_rtt != '1) ? lo_rtt : '0;
    s.max_rtt_us = hi_rtt;
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  function automatic prm_pkg::cmd_t req_of(input logic [2:0] a, input logic [47:0] t,
                                           input logic acc, input logic [63:0] st,
                                           input logic [15:0] len);
    prm_pkg::cmd_t c;
    c.action = a;
    c.now_ms = t;
    c.link_accepts = acc;
    c.resp_timestamp_us = st;
    c.resp_length = len;
    return c;
  endfunction

  function automatic prm_pkg::cmd_t next_request();
    prm_pkg::cmd_t c;
    int p;
    logic [47:0] t;
    logic [63:0] us;
    c.link_accepts = ($urandom_range(0, 4) != 0);
    c.resp_length = ($urandom_range(0, 5) != 0) ? prm_pkg::PACKET_BYTES : 16'($urandom);
    p = $urandom_range(0, 99);
    if (p < 3) begin
      clock_ms = 48'({$urandom, $urandom});
      t = clock_ms;
    end else if (p < 8) begin
      t = clock_ms - 48'($urandom_range(1, 5000));
    end else if (p < 14) begin
      clock_ms += {32'b0, cfg_timeout} + 48'($urandom_range(0, 2));
      t = clock_ms;
    end else begin
      clock_ms += 48'($urandom_range(0, cfg_interval + cfg_interval / 2));
      t = clock_ms;
    end
    c.now_ms = t;
    us = {16'b0, t} * 64'd1000;
    p = $urandom_range(0, 99);
    if (p < 75) c.resp_timestamp_us = us - 64'($urandom_range(0, 400000));
    else if (p < 88) c.resp_timestamp_us = {$urandom, $urandom};
    else c.resp_timestamp_us = us - {32'b0, $urandom};
    p = $urandom_range(0, 99);
    if (p < 50) c.action = prm_pkg::ACT_TICK;
    else if (p < 78) c.action = prm_pkg::ACT_RESP;
    else if (p < 86) c.action = prm_pkg::ACT_START;
    else if (p < 89) c.action = prm_pkg::ACT_STOP;
    else if (p < 92) c.action = prm_pkg::ACT_CLEAR;
    else if (p < 96) c.action = prm_pkg::ACT_CLEAR + 3'($urandom_range(1, 3));
    else c.action = prm_pkg::ACT_RESP;
    return c;
  endfunction

  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [13:0] v;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == prm_pkg::REG_INTERVAL) begin
      v = value[13:0];
      if (v < prm_pkg::INTERVAL_MIN) v = prm_pkg::INTERVAL_MIN;
      else if (v > prm_pkg::INTERVAL_MAX) v = prm_pkg::INTERVAL_MAX;
      cfg_interval = v;
    end else begin
      cfg_timeout = value[15:0];
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (req_queue.size() != 0 || stats_due.size() != 0) @(posedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!(cmd_valid && !cmd_took)) begin
      cmd_took = 1'b0;
      if (cmd_gap > 0) begin
        cmd_gap--;
        cmd_valid <= 1'b0;
      end else if (req_queue.size() == 0) begin
        cmd_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        cmd_gap = $urandom_range(0, 10);
        cmd_valid <= 1'b0;
      end else begin
        cmd_valid <= 1'b1;
        cmd <= req_queue[0];
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (stall_gap > 0) begin
      stall_gap--;
      stat_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_gap = $urandom_range(0, 10);
      stat_stall <= 1'b1;
    end else begin
      stat_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall) begin
        void'(req_queue.pop_front());
        predict_stats(cmd, want_stats);
        stats_due.push_back(want_stats);
        cmd_took = 1'b1;
      end
      if (stat_valid && !stat_stall) begin
        got_stats = stat;
        if (stats_due.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          want_stats = stats_due.pop_front();
          check_field("send_now", 64'(want_stats.send_now), 64'(got_stats.send_now));
          check_field("send_seq", 64'(want_stats.send_seq), 64'(got_stats.send_seq));
          check_field("send_stamp_us", 64'(want_stats.send_stamp_us),
                      64'(got_stats.send_stamp_us));
          check_field("event_kind", 64'(want_stats.event_kind), 64'(got_stats.event_kind));
          check_field("rtt_us", 64'(want_stats.rtt_us), 64'(got_stats.rtt_us));
          check_field("sent_count", 64'(want_stats.sent_count), 64'(got_stats.sent_count));
          check_field("received_count", 64'(want_stats.received_count),
                      64'(got_stats.received_count));
          check_field("lost_count", 64'(want_stats.lost_count), 64'(got_stats.lost_count));
          check_field("avg_rtt_us", 64'(want_stats.avg_rtt_us), 64'(got_stats.avg_rtt_us));
          check_field("min_rtt_us", 64'(want_stats.min_rtt_us), 64'(got_stats.min_rtt_us));
          check_field("max_rtt_us", 64'(want_stats.max_rtt_us), 64'(got_stats.max_rtt_us));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [31:0] interval_writes[5];
    logic [31:0] timeout_writes[5];
    interval_writes = '{32'd100, 32'h0000_3FFF, 32'd50, 32'hABCD_09C4, 32'd10000};
    timeout_writes = '{32'd1, 32'd65535, 32'd300, 32'd2000, 32'hDEAD_2EE0};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed requests with reset configuration
    req_queue.push_back(req_of(prm_pkg::ACT_TICK, 48'd5000, 1'b1, '0, prm_pkg::PACKET_BYTES));
    req_queue.push_back(req_of(prm_pkg::ACT_RESP, 48'd5000, 1'b1, '0, prm_pkg::PACKET_BYTES));
    req_queue.push_back(req_of(prm_pkg::ACT_STOP, '0, 1'b0, '0, '0));
    req_queue.push_back(req_of(prm_pkg::ACT_START, '0, 1'b0, '0, '0));
    req_queue.push_back(req_of(prm_pkg::ACT_START, '0, 1'b0, '0, '0));
    req_queue.push_back(req_of(prm_pkg::ACT_TICK, 48'd999, 1'b1, '0, '0));
    req_queue.push_back(req_of(prm_pkg::ACT_TICK, 48'd1000, 1'b0, '0, '0));
    req_queue.push_back(req_of(prm_pkg::ACT_TICK, 48'd1000, 1'b1, '0, '0));
    req_queue.push_back(req_of(prm_pkg::ACT_RESP, 48'd1001, 1'b1, 64'd1000000, 16'd15));
    req_queue.push_back(req_of(prm_pkg::ACT_RESP, 48'd1002, 1'b1, 64'd1000000,
                               prm_pkg::PACKET_BYTES));
    req_queue.push_back(req_of(prm_pkg::ACT_TICK, 48'd500, 1'b1, '0, '0));
    req_queue.push_back(req_of(prm_pkg::ACT_TICK, 48'd2000, 1'b1, '0, '0));
    req_queue.push_back(req_of(prm_pkg::ACT_TICK, 48'd7000, 1'b1, '0, '0));
    req_queue.push_back(req_of(prm_pkg::ACT_TICK, 48'd7001, 1'b1, '0, '0));
    req_queue.push_back(req_of(prm_pkg::ACT_CLEAR, '0, 1'b0, '0, '0));
    req_queue.push_back(req_of(prm_pkg::ACT_RESP, 48'd7002, 1'b1, 64'd7002000 - 64'hFFFF_FFFF,
                               prm_pkg::PACKET_BYTES));
    req_queue.push_back(req_of(prm_pkg::ACT_TICK, '1, 1'b1, '0, '0));
    req_queue.push_back(req_of(prm_pkg::ACT_RESP, '1, 1'b1, '1, prm_pkg::PACKET_BYTES));
    req_queue.push_back(req_of(prm_pkg::ACT_RESP, '1, 1'b1, '1, 16'hFFFF));
    for (int j = 1; j <= 3; j++) begin
      req_queue.push_back(req_of(prm_pkg::ACT_CLEAR + 3'(j), '1, 1'b1, '1,
                                 prm_pkg::PACKET_BYTES));
    end
    req_queue.push_back(req_of(prm_pkg::ACT_STOP, '0, 1'b0, '0, '0));
    req_queue.push_back(req_of(prm_pkg::ACT_TICK, 48'd9000, 1'b1, '0, '0));
    req_queue.push_back(req_of(prm_pkg::ACT_START, '0, 1'b0, '0, '0));
    req_queue.push_back(req_of(prm_pkg::ACT_TICK, '0, 1'b1, '0, '0));
    req_queue.push_back(req_of(prm_pkg::ACT_TICK, 48'd1000, 1'b1, '0, '0));
    drain();

    for (int k = 0; k < 5; k++) begin
      quiet = (k == 4);
      write_reg(prm_pkg::REG_INTERVAL, interval_writes[k]);
      write_reg(prm_pkg::REG_TIMEOUT, timeout_writes[k]);
      req_queue.push_back(req_of(prm_pkg::ACT_START, clock_ms, 1'b1, '0, '0));
      for (int n = 0; n < RANDOM_PER_PHASE; n++) req_queue.push_back(next_request());
      drain();
    end

    repeat (80) @(posedge clk);
    if (fails == 0 && stats_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/prm_pkg.sv
rtl/prm_div.sv
rtl/ping_rtt_monitor.sv
tb/sv/tb.sv
